// ----- rtl/core/frustum_sphere_box_cull_unit_defines.svh -----
// assertion macros for the frustum sphere/box cull unit
// used by frustum_sphere_box_cull_unit.sv, no other dependencies
`ifndef FRUSTUM_SPHERE_BOX_CULL_UNIT_DEFINES_SVH
`define FRUSTUM_SPHERE_BOX_CULL_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FSBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsbc same-cycle check failed");

// antecedent implies consequent in the next cycle
`define FSBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsbc next-cycle check failed");

`endif

// ----- rtl/core/fsbc_pkg.sv -----
// shared types and constants for the frustum sphere/box cull unit
// no dependencies; used by fsbc_cell, frustum_sphere_box_cull_unit and the testbench
package fsbc_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PROD_W      = 36;
   localparam int DIST_W      = 42;
   // two register stages per cell plus the result register
   localparam int PIPE_LATENCY = 2 * NUM_PLANES + 1;

   // csr register indexes, one per plane
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_4 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_5 = 3'd5;

   // cull reason codes
   localparam logic [1:0] REASON_VISIBLE = 2'd0;
   localparam logic [1:0] REASON_SPHERE  = 2'd1;
   localparam logic [1:0] REASON_BOX     = 2'd2;

   typedef struct packed {
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic signed [23:0] center_z;
      logic signed [23:0] half_x;
      logic signed [23:0] half_y;
      logic signed [23:0] half_z;
      logic        [23:0] sphere_radius;
   } req_type;

   typedef struct packed {
      logic       culled;
      logic [1:0] cull_reason;
   } rsp_type;

   // what one cell hands to the next
   typedef struct packed {
      logic    valid;
      logic    sphere_hit;
      logic    box_hit;
      req_type item;
   } cell_bus_type;

   // configuration write into one cell
   typedef struct packed {
      logic                  wr_en;
      logic [CSR_DATA_W-1:0] wr_data;
   } cell_cfg_type;

endpackage

// ----- rtl/core/fsbc_cell.sv -----
// one plane test cell: holds one frustum plane, tests the passing volume
// depends on fsbc_pkg
module fsbc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  fsbc_pkg::cell_cfg_type cfg,
   input  fsbc_pkg::cell_bus_type in_bus,
   output fsbc_pkg::cell_bus_type out_bus
);

   localparam int PW = fsbc_pkg::PROD_W;
   localparam int DW = fsbc_pkg::DIST_W;

   logic [fsbc_pkg::CSR_DATA_W-1:0] plane_ff;

   logic signed [11:0] nx, ny, nz;
   logic signed [27:0] w;

   // stage a registers
   fsbc_pkg::cell_bus_type a_bus_ff, a_bus_in;
   logic signed [PW-1:0] pcx_ff, pcy_ff, pcz_ff;
   logic signed [PW-1:0] phx_ff, phy_ff, phz_ff;
   logic signed [PW-1:0] pcx_in, pcy_in, pcz_in;
   logic signed [PW-1:0] phx_in, phy_in, phz_in;

   // stage b registers
   fsbc_pkg::cell_bus_type b_bus_ff, b_bus_in;

   logic signed [DW-1:0] w_term, rad_term, d_center, d_sphere, d_max;
   logic signed [DW-1:0] ax, ay, az;

   // plane register
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (cfg.wr_en) begin
         plane_ff <= cfg.wr_data;
      end
   end

   assign nx = plane_ff[11:0];
   assign ny = plane_ff[23:12];
   assign nz = plane_ff[35:24];
   assign w  = plane_ff[63:36];

   // stage a: normal times center and half-extent per axis
   always_comb begin
      a_bus_in = in_bus;
      pcx_in = PW'(nx) * PW'(in_bus.item.center_x);
      pcy_in = PW'(ny) * PW'(in_bus.item.center_y);
      pcz_in = PW'(nz) * PW'(in_bus.item.center_z);
      phx_in = PW'(nx) * PW'(in_bus.item.half_x);
      phy_in = PW'(ny) * PW'(in_bus.item.half_y);
      phz_in = PW'(nz) * PW'(in_bus.item.half_z);
   end

   // stage a register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_bus_ff.valid <= 1'b0;
      end else begin
         a_bus_ff.valid <= a_bus_in.valid;
      end
      a_bus_ff.sphere_hit <= a_bus_in.sphere_hit;
      a_bus_ff.box_hit    <= a_bus_in.box_hit;
      a_bus_ff.item       <= a_bus_in.item;
      pcx_ff <= pcx_in;
      pcy_ff <= pcy_in;
      pcz_ff <= pcz_in;
      phx_ff <= phx_in;
      phy_ff <= phy_in;
      phz_ff <= phz_in;
   end

   // stage b: center distance, sphere compare, farthest corner compare
   always_comb begin
      w_term   = {{(DW-38){w[27]}}, w, 10'b0};
      rad_term = {{(DW-34){1'b0}}, a_bus_ff.item.sphere_radius, 10'b0};
      d_center = DW'(pcx_ff) + DW'(pcy_ff) + DW'(pcz_ff) + w_term;
      d_sphere = d_center + rad_term;
      // the corner farthest along the normal takes |n*h| on every axis
      ax = phx_ff[PW-1] ? -DW'(phx_ff) : DW'(phx_ff);
      ay = phy_ff[PW-1] ? -DW'(phy_ff) : DW'(phy_ff);
      az = phz_ff[PW-1] ? -DW'(phz_ff) : DW'(phz_ff);
      d_max = d_center + ax + ay + az;
      b_bus_in = a_bus_ff;
      b_bus_in.sphere_hit = a_bus_ff.sphere_hit | d_sphere[DW-1];
      b_bus_in.box_hit    = a_bus_ff.box_hit | d_max[DW-1];
   end

   // stage b register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         b_bus_ff.valid <= 1'b0;
      end else begin
         b_bus_ff.valid <= b_bus_in.valid;
      end
      b_bus_ff.sphere_hit <= b_bus_in.sphere_hit;
      b_bus_ff.box_hit    <= b_bus_in.box_hit;
      b_bus_ff.item       <= b_bus_in.item;
   end

   assign out_bus = b_bus_ff;

endmodule

// ----- rtl/core/frustum_sphere_box_cull_unit.sv -----
// top level of the frustum sphere/box cull unit: a row of plane cells
// depends on fsbc_pkg, fsbc_cell and frustum_sphere_box_cull_unit_defines.svh
//
// channel   handshake            payload
// req       start / busy         req_data  (fsbc_pkg::req_type)
// rsp       rsp_valid strobe     rsp_data  (fsbc_pkg::rsp_type)
// csr       csr_valid/csr_ready  csr_index, csr_data
//
// one transaction per clock; busy never rises
// a result is registered through two stages in each of six plane cells
// plus the result register
// reset clears all planes to zero and drops every in-flight transaction
// the result side cannot stall, so nothing inside ever waits
`include "frustum_sphere_box_cull_unit_defines.svh"

module frustum_sphere_box_cull_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fsbc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output fsbc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsbc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NP = fsbc_pkg::NUM_PLANES;

   fsbc_pkg::cell_bus_type chain [NP+1];
   fsbc_pkg::cell_cfg_type cfg   [NP];

   logic              rsp_valid_ff, rsp_valid_in;
   fsbc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // head of the chain
   always_comb begin
      chain[0].valid      = start & ~busy;
      chain[0].sphere_hit = 1'b0;
      chain[0].box_hit    = 1'b0;
      chain[0].item       = req_data;
   end

   // row of plane cells
   for (genvar i = 0; i < NP; i++) begin : g_cell
      assign cfg[i].wr_en   = csr_valid & csr_ready
                              & (csr_index == fsbc_pkg::CSR_IDX_W'(i));
      assign cfg[i].wr_data = csr_data;

      fsbc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg[i]),
         .in_bus  (chain[i]),
         .out_bus (chain[i+1])
      );
   end

   // sphere rejection takes priority over box rejection
   always_comb begin
      rsp_valid_in = chain[NP].valid;
      if (chain[NP].sphere_hit) begin
         rsp_data_in.cull_reason = fsbc_pkg::REASON_SPHERE;
      end else if (chain[NP].box_hit) begin
         rsp_data_in.cull_reason = fsbc_pkg::REASON_BOX;
      end else begin
         rsp_data_in.cull_reason = fsbc_pkg::REASON_VISIBLE;
      end
      rsp_data_in.culled = chain[NP].sphere_hit | chain[NP].box_hit;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `FSBC_ASSERT_SAME(a_rsp_has_request, clock, reset, rsp_valid,
      $past(start, fsbc_pkg::PIPE_LATENCY))
   `FSBC_ASSERT_SAME(a_culled_matches_reason, clock, reset, rsp_valid,
      rsp_data.culled == (rsp_data.cull_reason != fsbc_pkg::REASON_VISIBLE))
   `FSBC_ASSERT_SAME(a_reason_legal, clock, reset, rsp_valid,
      rsp_data.cull_reason == fsbc_pkg::REASON_VISIBLE
      || rsp_data.cull_reason == fsbc_pkg::REASON_SPHERE
      || rsp_data.cull_reason == fsbc_pkg::REASON_BOX)
   `FSBC_ASSERT_NEXT(a_tail_to_rsp, clock, reset, chain[NP].valid, rsp_valid)

endmodule

// ----- tb/sv/frustum_sphere_box_cull_unit_checker.sv -----
// result checker for the frustum sphere/box cull unit: tracks plane writes,
// predicts a verdict per accepted transaction and compares it with each result
// depends on fsbc_pkg
`timescale 1ns / 1ps

module fsbc_cull_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  fsbc_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  fsbc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [fsbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fsbc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              failures,
   output int                              pending
);

   logic [fsbc_pkg::CSR_DATA_W-1:0] plane_regs [fsbc_pkg::NUM_PLANES];
   fsbc_pkg::rsp_type               verdict_queue [$];
   int                              mismatch_count = 0;

   // signed distance of a point to one plane, at scale 2^10
   function automatic longint plane_distance(
      input logic [fsbc_pkg::CSR_DATA_W-1:0] plane,
      input longint px, input longint py, input longint pz);
      longint nx, ny, nz, w;
      nx = longint'($signed(plane[11:0]));
      ny = longint'($signed(plane[23:12]));
      nz = longint'($signed(plane[35:24]));
      w  = longint'($signed(plane[63:36]));
      return nx * px + ny * py + nz * pz + w * 64'sd1024;
   endfunction

   // sphere test against every plane first, then the eight box corners
   function automatic fsbc_pkg::rsp_type predict_verdict(input fsbc_pkg::req_type item);
      longint            center [3];
      longint            half [3];
      longint            radius, px, py, pz;
      logic [1:0]        reason;
      bit                all_outside;
      fsbc_pkg::rsp_type verdict;
      center[0] = longint'($signed(item.center_x));
      center[1] = longint'($signed(item.center_y));
      center[2] = longint'($signed(item.center_z));
      half[0]   = longint'($signed(item.half_x));
      half[1]   = longint'($signed(item.half_y));
      half[2]   = longint'($signed(item.half_z));
      radius    = longint'({40'd0, item.sphere_radius}) * 64'sd1024;
      reason    = fsbc_pkg::REASON_VISIBLE;
      for (int i = 0; i < fsbc_pkg::NUM_PLANES; i++) begin
         if (reason == fsbc_pkg::REASON_VISIBLE &&
             plane_distance(plane_regs[i], center[0], center[1], center[2]) < -radius)
            reason = fsbc_pkg::REASON_SPHERE;
      end
      if (reason == fsbc_pkg::REASON_VISIBLE) begin
         for (int i = 0; i < fsbc_pkg::NUM_PLANES; i++) begin
            all_outside = 1'b1;
            for (int k = 0; k < 8; k++) begin
               px = ((k & 4) != 0) ? center[0] + half[0] : center[0] - half[0];
               py = ((k & 2) != 0) ? center[1] + half[1] : center[1] - half[1];
               pz = ((k & 1) != 0) ? center[2] + half[2] : center[2] - half[2];
               if (plane_distance(plane_regs[i], px, py, pz) >= 0)
                  all_outside = 1'b0;
            end
            if (all_outside)
               reason = fsbc_pkg::REASON_BOX;
         end
      end
      verdict.culled      = (reason != fsbc_pkg::REASON_VISIBLE);
      verdict.cull_reason = reason;
      return verdict;
   endfunction

   // watch the three channels at each edge
   always @(posedge clock) begin : watch_proc
      fsbc_pkg::rsp_type expected;
      if (reset) begin
         foreach (plane_regs[i])
            plane_regs[i] = '0;
         verdict_queue.delete();
      end else begin
         // plane writes; indexes past the last plane are dropped
         if (csr_valid && csr_ready && int'(csr_index) < fsbc_pkg::NUM_PLANES)
            plane_regs[csr_index] = csr_data;
         // accepted request transaction goes to the tail of the queue
         if (start && !busy)
            verdict_queue.insert(verdict_queue.size(), predict_verdict(req_data));
         // result transaction
         if (rsp_valid) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t: unexpected result culled=%0b reason=%0d", $time,
                        rsp_data.culled, rsp_data.cull_reason);
               mismatch_count++;
            end else begin
               expected = verdict_queue.pop_front();
               if (rsp_data.culled !== expected.culled) begin
                  $display("%0t: culled mismatch expected %0b actual %0b", $time,
                           expected.culled, rsp_data.culled);
                  mismatch_count++;
               end
               if (rsp_data.cull_reason !== expected.cull_reason) begin
                  $display("%0t: cull_reason mismatch expected %0d actual %0d", $time,
                           expected.cull_reason, rsp_data.cull_reason);
                  mismatch_count++;
               end
            end
         end
      end
      failures <= mismatch_count;
      pending  <= verdict_queue.size();
   end

endmodule

// ----- tb/sv/frustum_sphere_box_cull_unit_tb.sv -----
// top of the frustum sphere/box cull unit testbench: clock, reset, plane loads,
// directed and random volumes, watchdog and verdict
// depends on fsbc_pkg, frustum_sphere_box_cull_unit and fsbc_cull_checker
`timescale 1ns / 1ps

module frustum_sphere_box_cull_unit_tb;

   localparam int IDLE_LIMIT    = 2000;
   localparam int VOLUMES_CHUNK = 95;
   localparam int BOX_BOUND     = 1000;
   localparam int POS_MAX       = 8388607;
   localparam int POS_MIN       = -8388608;
   localparam int RADIUS_MAX    = 16777215;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   fsbc_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   fsbc_pkg::rsp_type               rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [fsbc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fsbc_pkg::CSR_DATA_W-1:0] csr_data = '0;
   int                              failures;
   int                              pending;
   int                              idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   frustum_sphere_box_cull_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   fsbc_cull_checker verdict_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   // random value of random magnitude, sign extended when asked
   function automatic logic [31:0] scaled_bits(input int unsigned max_width,
                                               input bit is_signed);
      int unsigned width;
      logic [31:0] mask, raw;
      width = ($urandom_range(3, 0) == 0) ? max_width : $urandom_range(max_width, 1);
      mask  = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
      raw   = $urandom & mask;
      if (is_signed && raw[width-1])
         raw = raw | ~mask;
      return raw;
   endfunction

   function automatic logic [fsbc_pkg::CSR_DATA_W-1:0] make_plane(
      input int nx, input int ny, input int nz, input int w);
      return {w[27:0], nz[11:0], ny[11:0], nx[11:0]};
   endfunction

   function automatic fsbc_pkg::req_type volume(input int cx, input int cy, input int cz,
                                                input int hx, input int hy, input int hz,
                                                input int r);
      fsbc_pkg::req_type item;
      item.center_x      = cx[23:0];
      item.center_y      = cy[23:0];
      item.center_z      = cz[23:0];
      item.half_x        = hx[23:0];
      item.half_y        = hy[23:0];
      item.half_z        = hz[23:0];
      item.sphere_radius = r[23:0];
      return item;
   endfunction

   function automatic fsbc_pkg::req_type random_volume();
      return volume(int'(scaled_bits(24, 1)), int'(scaled_bits(24, 1)),
                    int'(scaled_bits(24, 1)), int'(scaled_bits(24, 1)),
                    int'(scaled_bits(24, 1)), int'(scaled_bits(24, 1)),
                    int'(scaled_bits(24, 0)));
   endfunction

   // one csr transaction; the caller lowers csr_valid after its last write
   task automatic write_plane(input int idx,
                              input logic [fsbc_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx[fsbc_pkg::CSR_IDX_W-1:0];
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // axis aligned box frustum, |x|,|y|,|z| <= bound on every axis
   task automatic load_box_frustum(input int bound);
      write_plane(fsbc_pkg::CSR_PLANE_0, make_plane(1024, 0, 0, bound));
      write_plane(fsbc_pkg::CSR_PLANE_1, make_plane(-1024, 0, 0, bound));
      write_plane(fsbc_pkg::CSR_PLANE_2, make_plane(0, 1024, 0, bound));
      write_plane(fsbc_pkg::CSR_PLANE_3, make_plane(0, -1024, 0, bound));
      write_plane(fsbc_pkg::CSR_PLANE_4, make_plane(0, 0, 1024, bound));
      write_plane(fsbc_pkg::CSR_PLANE_5, make_plane(0, 0, -1024, bound));
   endtask

   // fresh plane set: random box, random normals or raw random words
   task automatic load_random_planes();
      int                              kind;
      int                              axis_normal [3];
      logic [fsbc_pkg::CSR_DATA_W-1:0] plane;
      kind = $urandom_range(2, 0);
      for (int i = 0; i < fsbc_pkg::NUM_PLANES; i++) begin
         case (kind)
            0: begin
               axis_normal = '{0, 0, 0};
               axis_normal[i / 2] = (i % 2 == 0) ? 1024 : -1024;
               plane = make_plane(axis_normal[0], axis_normal[1], axis_normal[2],
                                  int'(scaled_bits(27, 0)));
            end
            1: begin
               plane = make_plane(int'(scaled_bits(12, 1)), int'(scaled_bits(12, 1)),
                                  int'(scaled_bits(12, 1)), int'(scaled_bits(28, 1)));
            end
            default: begin
               plane = {$urandom, $urandom};
            end
         endcase
         write_plane(int'(fsbc_pkg::CSR_PLANE_0) + i, plane);
      end
      // sometimes poke one of the unused indexes, which must have no effect
      if ($urandom_range(3, 0) == 0)
         write_plane($urandom_range((1 << fsbc_pkg::CSR_IDX_W) - 1, fsbc_pkg::NUM_PLANES),
                     {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // one request transaction, after a random gap
   task automatic send_volume(input fsbc_pkg::req_type item);
      int gap;
      gap = 0;
      while (int'($urandom_range(99, 0)) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and wait until every predicted verdict has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // watchdog on cycles without any transaction
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL frustum_sphere_box_cull_unit");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // zero planes after reset: nothing may be culled
      send_volume(volume(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                         RADIUS_MAX));
      send_volume(volume(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, 0));
      send_volume(volume(0, 0, 0, 0, 0, 0, 0));
      send_volume(volume(POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, 1));
      drain_results();

      // box frustum plus writes to unused indexes that must be ignored
      load_box_frustum(BOX_BOUND);
      write_plane(fsbc_pkg::NUM_PLANES, '1);
      write_plane(fsbc_pkg::NUM_PLANES + 1, '1);
      csr_valid <= 1'b0;
      send_volume(volume(0, 0, 0, 0, 0, 0, 0));
      // center distance exactly minus radius: sphere keeps it, box rejects
      send_volume(volume(-BOX_BOUND - 10, 0, 0, 0, 0, 0, 10));
      send_volume(volume(-BOX_BOUND - 11, 0, 0, 0, 0, 0, 10));
      // one corner exactly on the plane counts as inside, either half sign
      send_volume(volume(-BOX_BOUND - 5, 0, 0, 5, 0, 0, 100));
      send_volume(volume(-BOX_BOUND - 5, 0, 0, -5, 0, 0, 100));
      send_volume(volume(-BOX_BOUND - 6, 0, 0, 5, 0, 0, 100));
      send_volume(volume(-BOX_BOUND - 6, 0, 0, -5, 0, 0, 100));
      send_volume(volume(0, 0, BOX_BOUND + 20, 0, 0, 10, 25));
      send_volume(volume(0, BOX_BOUND, 0, 0, 0, 0, 0));
      drain_results();

      // extreme and unnormalized planes against extreme volumes
      write_plane(fsbc_pkg::CSR_PLANE_0, make_plane(2047, 2047, 2047, 134217727));
      write_plane(fsbc_pkg::CSR_PLANE_1, make_plane(-2048, -2048, -2048, -134217728));
      write_plane(fsbc_pkg::CSR_PLANE_2, '1);
      write_plane(fsbc_pkg::CSR_PLANE_3, '0);
      write_plane(fsbc_pkg::CSR_PLANE_4, 64'h8000_0000_0000_0000);
      write_plane(fsbc_pkg::CSR_PLANE_5, make_plane(512, -300, 700, 12345));
      csr_valid <= 1'b0;
      send_volume(volume(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                         RADIUS_MAX));
      send_volume(volume(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                         RADIUS_MAX));
      send_volume(volume(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 0));
      send_volume(volume(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 0));
      send_volume(volume(POS_MAX, POS_MIN, POS_MAX, 0, 0, 0, 0));
      send_volume(volume(0, 0, 0, 0, 0, 0, RADIUS_MAX));

      // random volumes in three idle phases, new planes per chunk
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 84 : 0;
         for (int chunk = 0; chunk < 7; chunk++) begin
            drain_results();
            load_random_planes();
            repeat (VOLUMES_CHUNK) send_volume(random_volume());
         end
      end

      // let everything in flight come out, then a little more
      drain_results();
      repeat (fsbc_pkg::PIPE_LATENCY + 4) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS frustum_sphere_box_cull_unit");
      else
         $display("FAIL frustum_sphere_box_cull_unit");
      $finish;
   end

endmodule
